// File: design/meshset_to_triangle_list_defines.svh
// assertion macros for the mesh-set to triangle-list converter
// used by files that carry concurrent checks; expects clk and rst_n in scope
`ifndef MESHSET_TO_TRIANGLE_LIST_DEFINES_SVH
`define MESHSET_TO_TRIANGLE_LIST_DEFINES_SVH

`ifndef SYNTH

// check sampled on the clock, switched off while reset is applied
`define MSL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check sampled on the clock that also looks at the reset itself
`define MSL_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MSL_ASSERT(lbl, prop, msg)
`define MSL_ASSERT_RST(lbl, prop, msg)

`endif

`endif

// File: design/msl_pkg.sv
// shared types and constants of the mesh-set to triangle-list converter
// no dependencies
package msl_pkg;

    // set kinds
    localparam logic [1:0] KIND_TRI     = 2'd0;
    localparam logic [1:0] KIND_QUAD    = 2'd1;
    localparam logic [1:0] KIND_STRIP   = 2'd2;
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;

    // fault codes
    localparam logic [1:0] FAULT_OK    = 2'd0;
    localparam logic [1:0] FAULT_KIND  = 2'd1;
    localparam logic [1:0] FAULT_RANGE = 2'd2;

    // configuration register indexes
    localparam logic CFG_BASE_VERTEX = 1'b0;
    localparam logic CFG_AREA_CODE   = 1'b1;

    // strip header layout
    localparam logic [15:0] STRIP_LEN_MASK = 16'h7FFF;
    localparam logic [15:0] STRIP_WIND_BIT = 16'h8000;

    localparam int CFG_DATA_BITS = 24;
    localparam int VERT_BITS     = 24;

    typedef struct packed {
        logic        set_start;
        logic [1:0]  set_kind;
        logic [15:0] mesh_word;
    } word_item_t;

    typedef struct packed {
        logic [VERT_BITS-1:0] vert_a;
        logic [VERT_BITS-1:0] vert_b;
        logic [VERT_BITS-1:0] vert_c;
        logic [7:0]           tri_area;
        logic [1:0]           fault;
    } tri_item_t;

    // triangle request from the sequencer to the offset stage
    typedef struct packed {
        logic        emit;
        logic        bad_kind;
        logic [15:0] idx_a;
        logic [15:0] idx_b;
        logic [15:0] idx_c;
    } tri_req_t;

endpackage

// File: design/msl_sequencer.sv
// set/strip tracking: held indices, slot and strip counters, winding
// depends on msl_pkg and the assertion macro header
`include "meshset_to_triangle_list_defines.svh"

module msl_sequencer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  msl_pkg::word_item_t item,
    output msl_pkg::tri_req_t  req
);
    import msl_pkg::*;

    logic [1:0]  cur_kind_reg, cur_kind_next;
    logic [1:0]  slot_count_reg, slot_count_next;
    logic [14:0] strip_left_reg, strip_left_next;
    logic [1:0]  strip_seen_reg, strip_seen_next;
    logic        winding_flip_reg, winding_flip_next;
    logic        want_header_reg, want_header_next;
    logic [15:0] held_reg [3];
    logic [15:0] held_next [3];

    logic [1:0]  eff_kind;
    logic [1:0]  eff_slot;
    logic [14:0] eff_left;
    logic [1:0]  eff_seen;
    logic        eff_flip;
    logic        eff_want;
    logic [14:0] left_dec;
    logic [15:0] w;

    always_comb
    begin
        w        = item.mesh_word;
        // a set start wipes the running state before the word is used
        eff_kind = item.set_start ? item.set_kind : cur_kind_reg;
        eff_slot = item.set_start ? 2'd0 : slot_count_reg;
        eff_left = item.set_start ? 15'd0 : strip_left_reg;
        eff_seen = item.set_start ? 2'd0 : strip_seen_reg;
        eff_flip = item.set_start ? 1'b0 : winding_flip_reg;
        eff_want = item.set_start ? 1'b1 : want_header_reg;
        left_dec = eff_left - 15'd1;

        cur_kind_next     = eff_kind;
        slot_count_next   = eff_slot;
        strip_left_next   = eff_left;
        strip_seen_next   = eff_seen;
        winding_flip_next = eff_flip;
        want_header_next  = eff_want;
        held_next         = held_reg;
        req               = '0;

        unique case (eff_kind)
            KIND_TRI:
            begin
                if (eff_slot == 2'd2)
                begin
                    held_next[2]    = w;
                    slot_count_next = 2'd0;
                    req.emit        = 1'b1;
                    req.idx_a       = held_reg[0];
                    req.idx_b       = held_reg[1];
                    req.idx_c       = w;
                end
                else
                begin
                    held_next[eff_slot[0]] = w;
                    slot_count_next        = eff_slot + 2'd1;
                end
            end
            KIND_QUAD:
            begin
                slot_count_next = eff_slot + 2'd1;
                if (eff_slot == 2'd3)
                begin
                    req.emit  = 1'b1;
                    req.idx_a = held_reg[2];
                    req.idx_b = held_reg[1];
                    req.idx_c = w;
                end
                else
                begin
                    held_next[eff_slot] = w;
                    if (eff_slot == 2'd2)
                    begin
                        req.emit  = 1'b1;
                        req.idx_a = held_reg[0];
                        req.idx_b = held_reg[1];
                        req.idx_c = w;
                    end
                end
            end
            KIND_STRIP:
            begin
                if (eff_want)
                begin
                    strip_left_next   = w[14:0] & STRIP_LEN_MASK[14:0];
                    winding_flip_next = (w & STRIP_WIND_BIT) != 16'd0;
                    strip_seen_next   = 2'd0;
                    want_header_next  = (w[14:0] & STRIP_LEN_MASK[14:0]) == 15'd0;
                end
                else
                begin
                    strip_left_next = left_dec;
                    if (eff_seen < 2'd2)
                    begin
                        held_next[eff_seen[0]] = w;
                        strip_seen_next        = eff_seen + 2'd1;
                    end
                    else
                    begin
                        req.emit          = 1'b1;
                        req.idx_a         = eff_flip ? held_reg[1] : held_reg[0];
                        req.idx_b         = eff_flip ? held_reg[0] : held_reg[1];
                        req.idx_c         = w;
                        held_next[0]      = held_reg[1];
                        held_next[1]      = w;
                        winding_flip_next = ~eff_flip;
                    end
                    want_header_next = (left_dec == 15'd0);
                end
            end
            KIND_UNKNOWN:
            begin
                // only the set start word reports; the rest of the set is dropped
                if (item.set_start)
                begin
                    req.emit     = 1'b1;
                    req.bad_kind = 1'b1;
                end
            end
            default:
            begin
                req = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_kind_reg     <= KIND_TRI;
            slot_count_reg   <= 2'd0;
            strip_left_reg   <= 15'd0;
            strip_seen_reg   <= 2'd0;
            winding_flip_reg <= 1'b0;
            want_header_reg  <= 1'b1;
        end
        else if (step)
        begin
            cur_kind_reg     <= cur_kind_next;
            slot_count_reg   <= slot_count_next;
            strip_left_reg   <= strip_left_next;
            strip_seen_reg   <= strip_seen_next;
            winding_flip_reg <= winding_flip_next;
            want_header_reg  <= want_header_next;
        end
    end

    // index store, written before read so no reset
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            held_reg <= held_next;
        end
    end

    `MSL_ASSERT(a_tri_slot_range,
        cur_kind_reg != KIND_TRI || slot_count_reg != 2'd3,
        "triangle-list slot counter reached three")
    `MSL_ASSERT(a_strip_body_left,
        (cur_kind_reg == KIND_STRIP && !want_header_reg) |-> strip_left_reg != 15'd0,
        "strip body open with no words left")
    `MSL_ASSERT(a_strip_seen_range,
        strip_seen_reg != 2'd3,
        "strip seen counter overran")

endmodule

// File: design/msl_offset.sv
// base vertex offset, range check and result formatting
// depends on msl_pkg
module msl_offset #(
    parameter int VERTEX_INDEX_BITS = 24
) (
    input  msl_pkg::tri_req_t  req,
    input  logic [23:0]        base_vertex,
    input  logic [7:0]         area_code,
    output msl_pkg::tri_item_t item
);
    import msl_pkg::*;

    localparam logic [32:0] LIMIT = (33'd1 << VERTEX_INDEX_BITS) - 33'd1;

    logic [24:0] sum_a;
    logic [24:0] sum_b;
    logic [24:0] sum_c;
    logic        over;

    always_comb
    begin
        sum_a = {1'b0, base_vertex} + {9'd0, req.idx_a};
        sum_b = {1'b0, base_vertex} + {9'd0, req.idx_b};
        sum_c = {1'b0, base_vertex} + {9'd0, req.idx_c};
        over  = ({8'd0, sum_a} > LIMIT) || ({8'd0, sum_b} > LIMIT)
                || ({8'd0, sum_c} > LIMIT);

        item          = '0;
        item.tri_area = area_code;
        if (req.bad_kind)
        begin
            item.fault = FAULT_KIND;
        end
        else if (over)
        begin
            item.fault = FAULT_RANGE;
        end
        else
        begin
            item.vert_a = sum_a[VERT_BITS-1:0];
            item.vert_b = sum_b[VERT_BITS-1:0];
            item.vert_c = sum_c[VERT_BITS-1:0];
            item.fault  = FAULT_OK;
        end
    end

endmodule

// File: design/meshset_to_triangle_list.sv
// top level of the mesh-set to triangle-list converter
// depends on msl_pkg, msl_sequencer, msl_offset and the assertion macro header
//
//   channel  direction  handshake              payload
//   word     in         word_valid/word_stall  word_item (set_start, set_kind, mesh_word)
//   tri      out        tri_valid/tri_stall    tri_item (vert_a/b/c, tri_area, fault)
//   cfg      in         cfg_we                 cfg_index, cfg_data
//
// one word per cycle while the result is not stalled; a word is registered at its accepting edge
// and its triangle (if any) is loaded into the result register when that word moves on;
// the sequencer state update and the three offset adders lie between the two registers
// rst_n clears the valid flags and the set/strip state, held indices come up unknown
// a stalled result holds the word in the input register and stalls the input; an empty
// input register still takes a word while the result waits
`include "meshset_to_triangle_list_defines.svh"

module meshset_to_triangle_list #(
    parameter int VERTEX_INDEX_BITS = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    // word channel
    input  logic                word_valid,
    output logic                word_stall,
    input  msl_pkg::word_item_t word_item,
    // triangle channel
    output logic                tri_valid,
    input  logic                tri_stall,
    output msl_pkg::tri_item_t  tri_item,
    // configuration writes
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [23:0]         cfg_data
);
    import msl_pkg::*;

    // configuration registers
    logic [23:0] base_vertex_reg;
    logic [7:0]  area_code_reg;

    // input register stage
    logic       s1_valid_reg, s1_valid_next;
    word_item_t s1_item_reg;

    // result register stage
    logic       tri_valid_reg, tri_valid_next;
    tri_item_t  tri_item_reg;

    logic       out_free;
    logic       step;
    logic       word_take;
    tri_req_t   req;
    tri_item_t  tri_comb;

    // result register is free when empty or being drained this cycle
    assign out_free   = !tri_valid_reg || !tri_stall;
    // the registered word moves on whenever there is room for its result
    assign step       = s1_valid_reg && out_free;
    // input register refills as soon as its word moves on
    assign word_stall = s1_valid_reg && !out_free;
    assign word_take  = word_valid && !word_stall;

    assign tri_valid  = tri_valid_reg;
    assign tri_item   = tri_item_reg;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (word_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (step)
        begin
            s1_valid_next = 1'b0;
        end

        tri_valid_next = tri_valid_reg;
        if (out_free)
        begin
            tri_valid_next = step && req.emit;
        end
    end

    msl_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (s1_item_reg),
        .req   (req)
    );

    msl_offset #(
        .VERTEX_INDEX_BITS (VERTEX_INDEX_BITS)
    ) u_offset (
        .req         (req),
        .base_vertex (base_vertex_reg),
        .area_code   (area_code_reg),
        .item        (tri_comb)
    );

    // control and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            tri_valid_reg   <= 1'b0;
            base_vertex_reg <= 24'd0;
            area_code_reg   <= 8'd0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            tri_valid_reg <= tri_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_BASE_VERTEX: base_vertex_reg <= cfg_data;
                    CFG_AREA_CODE:   area_code_reg   <= cfg_data[7:0];
                    default:         base_vertex_reg <= base_vertex_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (word_take)
        begin
            s1_item_reg <= word_item;
        end
        if (step && req.emit)
        begin
            tri_item_reg <= tri_comb;
        end
    end

    // a faulted triangle never carries vertex indices
    `MSL_ASSERT(a_fault_zero_verts,
        (tri_valid_reg && tri_item_reg.fault != FAULT_OK) |->
            (tri_item_reg.vert_a == 24'd0 && tri_item_reg.vert_b == 24'd0
             && tri_item_reg.vert_c == 24'd0),
        "faulted triangle carries vertex indices")
    // a registered word that could not move on is still held next cycle
    `MSL_ASSERT(a_word_kept,
        (s1_valid_reg && !step) |=> s1_valid_reg,
        "held word lost from input register")
    // a fresh result always comes from a word in the input register
    `MSL_ASSERT(a_result_source,
        (tri_valid_reg && !$past(tri_valid_reg)) |-> $past(s1_valid_reg),
        "result appeared with no word behind it")
    // reset empties both stages
    `MSL_ASSERT_RST(a_reset_empty,
        !rst_n |=> (!tri_valid_reg && !s1_valid_reg),
        "stage valid set during reset")

endmodule

// File: tb/sv/testbench.sv
// self-checking testbench for the mesh-set to triangle-list converter
// predicts every triangle from the word stream and checks each result transaction in order
// depends on msl_pkg and the meshset_to_triangle_list top level
module testbench;
    import msl_pkg::*;

    // predicts triangles from accepted words and holds them until the block delivers them
    class triangle_checker;
        tri_item_t   pending_tris[$];
        int          errors;
        // copies of the two registers
        logic [23:0] base;
        logic [7:0]  area;
        // stream state
        logic [1:0]  set_kind_r;
        logic [1:0]  slot;
        logic [15:0] idx_hold[3];
        logic [14:0] strip_rem;
        logic [1:0]  strip_cnt;
        logic        flip;
        logic        need_hdr;

        function new();
            errors     = 0;
            base       = '0;
            area       = '0;
            set_kind_r = KIND_TRI;
            slot       = '0;
            strip_rem  = '0;
            strip_cnt  = '0;
            flip       = 1'b0;
            need_hdr   = 1'b1;
            for (int i = 0; i < 3; i++)
                idx_hold[i] = '0;
        endfunction

        function void set_config(logic [23:0] b, logic [7:0] a);
            base = b;
            area = a;
        endfunction

        function int pending();
            return pending_tris.size();
        endfunction

        // append one expected triangle at the tail
        function void queue_tri(tri_item_t t);
            pending_tris.insert(pending_tris.size(), t);
        endfunction

        // offset the three indices; any sum past the index range gives a range fault
        function void push_triangle(logic [15:0] a, logic [15:0] b, logic [15:0] c);
            logic [VERT_BITS:0] sa;
            logic [VERT_BITS:0] sb;
            logic [VERT_BITS:0] sc;
            tri_item_t t;
            sa = {1'b0, base} + a;
            sb = {1'b0, base} + b;
            sc = {1'b0, base} + c;
            t.tri_area = area;
            if (sa[VERT_BITS] || sb[VERT_BITS] || sc[VERT_BITS])
            begin
                t.vert_a = '0;
                t.vert_b = '0;
                t.vert_c = '0;
                t.fault  = FAULT_RANGE;
            end
            else
            begin
                t.vert_a = sa[VERT_BITS-1:0];
                t.vert_b = sb[VERT_BITS-1:0];
                t.vert_c = sc[VERT_BITS-1:0];
                t.fault  = FAULT_OK;
            end
            queue_tri(t);
        endfunction

        function void take_word(word_item_t w);
            logic [1:0] s;
            tri_item_t  t;
            if (w.set_start)
            begin
                set_kind_r = w.set_kind;
                slot       = '0;
                strip_rem  = '0;
                strip_cnt  = '0;
                flip       = 1'b0;
                need_hdr   = 1'b1;
                if (w.set_kind == KIND_UNKNOWN)
                begin
                    t.vert_a   = '0;
                    t.vert_b   = '0;
                    t.vert_c   = '0;
                    t.tri_area = area;
                    t.fault    = FAULT_KIND;
                    queue_tri(t);
                    return;
                end
            end
            case (set_kind_r)
                KIND_TRI:
                begin
                    idx_hold[slot] = w.mesh_word;
                    slot = slot + 2'd1;
                    if (slot == 2'd3)
                    begin
                        slot = '0;
                        push_triangle(idx_hold[0], idx_hold[1], idx_hold[2]);
                    end
                end
                KIND_QUAD:
                begin
                    s    = slot;
                    slot = s + 2'd1;
                    if (s == 2'd3)
                        push_triangle(idx_hold[2], idx_hold[1], w.mesh_word);
                    else
                    begin
                        idx_hold[s] = w.mesh_word;
                        if (s == 2'd2)
                            push_triangle(idx_hold[0], idx_hold[1], idx_hold[2]);
                    end
                end
                KIND_STRIP:
                begin
                    if (need_hdr)
                    begin
                        strip_rem = w.mesh_word[14:0];
                        flip      = (w.mesh_word & STRIP_WIND_BIT) != 0;
                        strip_cnt = '0;
                        need_hdr  = (strip_rem == 0);
                    end
                    else
                    begin
                        strip_rem = strip_rem - 15'd1;
                        if (strip_cnt < 2)
                        begin
                            idx_hold[strip_cnt] = w.mesh_word;
                            strip_cnt = strip_cnt + 2'd1;
                        end
                        else
                        begin
                            if (!flip)
                                push_triangle(idx_hold[0], idx_hold[1], w.mesh_word);
                            else
                                push_triangle(idx_hold[1], idx_hold[0], w.mesh_word);
                            idx_hold[0] = idx_hold[1];
                            idx_hold[1] = w.mesh_word;
                            flip = ~flip;
                        end
                        if (strip_rem == 0)
                            need_hdr = 1'b1;
                    end
                end
                default:
                    ;
            endcase
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_triangle(tri_item_t got);
            tri_item_t want;
            if (pending_tris.size() == 0)
            begin
                $display("%0t: unexpected triangle, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending_tris.pop_front();
            compare_field("vert_a", want.vert_a, got.vert_a);
            compare_field("vert_b", want.vert_b, got.vert_b);
            compare_field("vert_c", want.vert_c, got.vert_c);
            compare_field("tri_area", want.tri_area, got.tri_area);
            compare_field("fault", want.fault, got.fault);
        endfunction
    endclass

    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 192;
    localparam int LONG_HOLD   = 80;

    logic        clk;
    logic        rst_n;
    logic        word_valid;
    logic        word_stall;
    word_item_t  word_item;
    logic        tri_valid;
    logic        tri_stall;
    tri_item_t   tri_item;
    logic        cfg_we;
    logic        cfg_index;
    logic [23:0] cfg_data;

    triangle_checker tracker;
    word_item_t      word_queue[$];
    // no idling on either side while set
    bit              quiet;
    // asks the receiver for one long stall stretch
    bit              hold_request;

    meshset_to_triangle_list dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (word_valid),
        .word_stall (word_stall),
        .word_item  (word_item),
        .tri_valid  (tri_valid),
        .tri_stall  (tri_stall),
        .tri_item   (tri_item),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // both channels are sampled at the edge, before any update of this step lands
    always @(posedge clk)
    begin
        if (rst_n && word_valid && !word_stall)
            tracker.take_word(word_item);
        if (rst_n && tri_valid && !tri_stall)
            tracker.check_triangle(tri_item);
    end

    // stream builders

    // append one word at the tail of the stream
    function automatic void add_word(word_item_t it);
        word_queue.insert(word_queue.size(), it);
    endfunction

    function automatic word_item_t make_word(bit st, logic [1:0] kind, logic [15:0] w);
        word_item_t it;
        it.set_start = st;
        it.set_kind  = kind;
        it.mesh_word = w;
        return it;
    endfunction

    // mostly small indices, with full-range values and both extremes mixed in
    function automatic logic [15:0] pick_index();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 15));
            1: return 16'($urandom);
            2: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: return 16'($urandom_range(0, 255));
        endcase
    endfunction

    // triangle-list set, sometimes with a dangling partial group
    function automatic int add_tri_set();
        int n;
        n = 3 * $urandom_range(1, 5);
        if ($urandom_range(0, 5) == 0)
            n += $urandom_range(1, 2);
        for (int i = 0; i < n; i++)
            add_word(make_word(i == 0, KIND_TRI, pick_index()));
        return n;
    endfunction

    // quad-list set, sometimes cut short inside a group
    function automatic int add_quad_set();
        int n;
        n = 4 * $urandom_range(1, 4);
        if ($urandom_range(0, 5) == 0)
            n += $urandom_range(1, 3);
        for (int i = 0; i < n; i++)
            add_word(make_word(i == 0, KIND_QUAD, pick_index()));
        return n;
    endfunction

    // strip set: one to four complete strips, occasionally followed by one broken off mid-way
    function automatic int add_strip_set();
        int          n;
        int          len;
        int          r;
        logic [15:0] hdr;
        n = 0;
        for (int s = $urandom_range(1, 4); s > 0; s--)
        begin
            r   = $urandom_range(0, 9);
            len = (r < 2) ? $urandom_range(0, 2) : (r < 9) ? $urandom_range(3, 10)
                                                           : $urandom_range(11, 30);
            hdr = {1'($urandom_range(0, 1)), 15'(len)};
            add_word(make_word(n == 0, KIND_STRIP, hdr));
            n++;
            for (int i = 0; i < len; i++)
            begin
                add_word(make_word(1'b0, KIND_STRIP, pick_index()));
                n++;
            end
        end
        if ($urandom_range(0, 11) == 0)
        begin
            hdr = {1'($urandom_range(0, 1)), 15'($urandom_range(3, 32767))};
            add_word(make_word(1'b0, KIND_STRIP, hdr));
            n++;
            for (int i = $urandom_range(0, 5); i > 0; i--)
            begin
                add_word(make_word(1'b0, KIND_STRIP, pick_index()));
                n++;
            end
        end
        return n;
    endfunction

    // unknown kind: only the start word counts, the rest is ignored by the block
    function automatic int add_unknown_set();
        add_word(make_word(1'b1, KIND_UNKNOWN, 16'($urandom)));
        for (int i = $urandom_range(0, 3); i > 0; i--)
            add_word(make_word(1'($urandom_range(0, 1)) & 1'b0, 2'($urandom),
                               16'($urandom)));
        return 1;
    endfunction

    // fully random fields, set starts now and then
    function automatic int add_noise();
        int n;
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
            add_word(make_word($urandom_range(0, 3) == 0, 2'($urandom),
                               16'($urandom)));
        return n;
    endfunction

    // short directed stream, run with a base that lets 0xFFFF overflow
    task automatic add_directed();
        // words before any set start behave as a triangle list
        add_word(make_word(1'b0, KIND_TRI, 16'd10));
        add_word(make_word(1'b0, KIND_TRI, 16'd20));
        add_word(make_word(1'b0, KIND_TRI, 16'd30));
        // index out of range
        add_word(make_word(1'b1, KIND_TRI, 16'h0000));
        add_word(make_word(1'b0, KIND_TRI, 16'hFFFF));
        add_word(make_word(1'b0, KIND_TRI, 16'h0001));
        // quad reaching the top of the index range exactly
        add_word(make_word(1'b1, KIND_QUAD, 16'hFFFE));
        add_word(make_word(1'b0, KIND_QUAD, 16'd0));
        add_word(make_word(1'b0, KIND_QUAD, 16'd7));
        add_word(make_word(1'b0, KIND_QUAD, 16'd9));
        // strips: length zero, length two, flipped length three, longest header cut off
        add_word(make_word(1'b1, KIND_STRIP, 16'h0000));
        add_word(make_word(1'b0, KIND_STRIP, 16'h0002));
        add_word(make_word(1'b0, KIND_STRIP, 16'd4));
        add_word(make_word(1'b0, KIND_STRIP, 16'd5));
        add_word(make_word(1'b0, KIND_STRIP, 16'h8003));
        add_word(make_word(1'b0, KIND_STRIP, 16'd1));
        add_word(make_word(1'b0, KIND_STRIP, 16'd2));
        add_word(make_word(1'b0, KIND_STRIP, 16'd3));
        add_word(make_word(1'b0, KIND_STRIP, 16'hFFFF));
        add_word(make_word(1'b0, KIND_STRIP, 16'h1234));
        add_word(make_word(1'b0, KIND_STRIP, 16'h5678));
        add_word(make_word(1'b0, KIND_STRIP, 16'h9ABC));
        // unknown kind, then a word it must ignore
        add_word(make_word(1'b1, KIND_UNKNOWN, 16'hFFFF));
        add_word(make_word(1'b0, KIND_TRI, 16'h0000));
    endtask

    // drivers

    // both registers written back to back while the block is idle
    task automatic load_config(logic [23:0] b, logic [7:0] a);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_BASE_VERTEX;
        cfg_data  <= b;
        @(posedge clk);
        cfg_index <= CFG_AREA_CODE;
        cfg_data  <= {16'h0000, a};
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.set_config(b, a);
        @(posedge clk);
    endtask

    // offer each queued word, with a random gap after each accepted transaction
    task automatic send_words();
        word_item_t it;
        int         gap;
        while (word_queue.size() > 0)
        begin
            it = word_queue.pop_front();
            word_valid <= 1'b1;
            word_item  <= it;
            do
                @(posedge clk);
            while (word_stall);
            gap = quiet ? 0 : $urandom_range(0, 9);
            if (gap > 0)
            begin
                word_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        word_valid <= 1'b0;
    endtask

    // wait for all triangles, then a further wait for words with no result
    task automatic settle_block();
        for (int k = 0; k < 5000 && tracker.pending() != 0; k++)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // receiver: random stall before each transaction, one long stretch on request
    initial
    begin : receiver
        int hold;
        tri_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                hold = LONG_HOLD;
                hold_request = 1'b0;
            end
            else
                hold = quiet ? 0 : $urandom_range(0, 9);
            if (hold > 0)
            begin
                tri_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            tri_stall <= 1'b0;
            do
                @(posedge clk);
            while (!tri_valid);
        end
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin : watchdog
        #4000000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin : main_sequence
        int          made;
        logic [23:0] b;
        logic [7:0]  a;
        tracker      = new();
        quiet        = 1'b0;
        hold_request = 1'b0;
        rst_n        = 1'b0;
        word_valid   = 1'b0;
        word_item    = '0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_BASE_VERTEX;
        cfg_data     = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        load_config(24'hFF0001, 8'hA5);
        add_directed();
        send_words();
        settle_block();

        // random phases, each with its own register setting
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: begin b = 24'h000000; a = 8'h00; end
                1: begin b = 24'hFF0000; a = 8'hFF; end
                2: begin b = 24'hFFFFFF; a = 8'h01; end
                3: begin b = 24'($urandom_range(0, 24'hFF0000)); a = 8'($urandom); end
                4: begin b = 24'hFF8000 | 24'($urandom_range(0, 16'h7FFF)); a = 8'($urandom); end
                default: begin b = 24'($urandom); a = 8'($urandom); end
            endcase
            load_config(b, a);
            // first phase runs flat out, second fills the block behind a long stall
            quiet = (ph == 0);
            hold_request = (ph == 1);
            made = 0;
            while (made < PHASE_ITEMS)
            begin
                case ($urandom_range(0, 99)) inside
                    [0:24]:  made += add_tri_set();
                    [25:49]: made += add_quad_set();
                    [50:79]: made += add_strip_set();
                    [80:87]: made += add_unknown_set();
                    default: made += add_noise();
                endcase
            end
            send_words();
            settle_block();
        end

        if (tracker.pending() != 0)
        begin
            $display("%0t: %0d triangles expected, actual none", $time, tracker.pending());
            tracker.errors++;
        end
        if (tracker.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/msl_pkg.sv
design/msl_sequencer.sv
design/msl_offset.sv
design/meshset_to_triangle_list.sv
tb/sv/testbench.sv
